FILE: rtl/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constant tables for the application port classifier.
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int PORT_W   = 16;
    localparam int CLASS_W  = 6;
    localparam int LEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int PROTO_W  = 8;
    localparam int NUM_TCP  = 32;
    localparam int NUM_UDP  = 16;

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 6'd0;
    localparam logic [CLASS_W-1:0] CLASS_HTTP    = 6'd1;
    localparam logic [CLASS_W-1:0] CLASS_SSH     = 6'd4;
    localparam logic [CLASS_W-1:0] CLASS_SMTP    = 6'd6;
    localparam logic [CLASS_W-1:0] CLASS_MAX     = 6'd47;

    typedef logic [PORT_W-1:0]  t_port;
    typedef logic [CLASS_W-1:0] t_class;
    typedef logic [BYTE_W-1:0]  t_byte;

    // one classification outcome from either matcher
    typedef struct packed {
        logic   hit;
        t_class code;
    } t_match;

    localparam t_port TCP_PORTS [NUM_TCP] = '{
        16'd80,   16'd443,  16'd21,    16'd22,   16'd23,   16'd25,   16'd110,
        16'd143,  16'd993,  16'd995,   16'd3306, 16'd5432, 16'd3389,
        16'd1723, 16'd5900, 16'd5222,  16'd5223, 16'd5060, 16'd8080,
        16'd8443, 16'd6697, 16'd6667,  16'd27017, 16'd1433, 16'd3128,
        16'd5601, 16'd9200, 16'd9300,  16'd6379, 16'd11211, 16'd5672,
        16'd15672
    };

    // tcp codes run densely 1..32 in list order
    localparam t_class TCP_CODES [NUM_TCP] = '{
        6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,
        6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
        6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
        6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32
    };

    localparam t_port UDP_PORTS [NUM_UDP] = '{
        16'd53,   16'd67,   16'd68,   16'd69,   16'd123,  16'd161,
        16'd162,  16'd500,  16'd514,  16'd1194, 16'd1701, 16'd1812,
        16'd1813, 16'd4500, 16'd5353, 16'd5060
    };

    // sip shares its code with the tcp entry
    localparam t_class UDP_CODES [NUM_UDP] = '{
        6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
        6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd18
    };

endpackage

FILE: rtl/apc_port_match.sv
// ----------------------------------------------------------------------------
// apc_port_match
// Priority match of source and destination port against the tcp or udp list.
// ----------------------------------------------------------------------------
module apc_port_match (
    input  logic [apc_pkg::PROTO_W-1:0] i_ip_protocol,
    input  apc_pkg::t_port              i_source_port,
    input  apc_pkg::t_port              i_dest_port,
    output apc_pkg::t_match             o_match
);

    logic [apc_pkg::NUM_TCP-1:0] tcp_hit;
    logic [apc_pkg::NUM_UDP-1:0] udp_hit;
    apc_pkg::t_match             tcp_sel;
    apc_pkg::t_match             udp_sel;

    always_comb begin
        for (int i = 0; i < apc_pkg::NUM_TCP; i++) begin
            tcp_hit[i] = (apc_pkg::TCP_PORTS[i] == i_source_port) ||
                         (apc_pkg::TCP_PORTS[i] == i_dest_port);
        end
        for (int i = 0; i < apc_pkg::NUM_UDP; i++) begin
            udp_hit[i] = (apc_pkg::UDP_PORTS[i] == i_source_port) ||
                         (apc_pkg::UDP_PORTS[i] == i_dest_port);
        end
    end

    // walk from the back so the earliest listed hit wins
    always_comb begin
        tcp_sel = '{hit: 1'b0, code: apc_pkg::CLASS_UNKNOWN};
        for (int i = apc_pkg::NUM_TCP - 1; i >= 0; i--) begin
            if (tcp_hit[i]) begin
                tcp_sel = '{hit: 1'b1, code: apc_pkg::TCP_CODES[i]};
            end
        end
        udp_sel = '{hit: 1'b0, code: apc_pkg::CLASS_UNKNOWN};
        for (int i = apc_pkg::NUM_UDP - 1; i >= 0; i--) begin
            if (udp_hit[i]) begin
                udp_sel = '{hit: 1'b1, code: apc_pkg::UDP_CODES[i]};
            end
        end
    end

    always_comb begin
        if (i_ip_protocol == apc_pkg::PROTO_TCP) begin
            o_match = tcp_sel;
        end else if (i_ip_protocol == apc_pkg::PROTO_UDP) begin
            o_match = udp_sel;
        end else begin
            o_match = '{hit: 1'b0, code: apc_pkg::CLASS_UNKNOWN};
        end
    end

endmodule

FILE: rtl/apc_sig_match.sv
// ----------------------------------------------------------------------------
// apc_sig_match
// Leading payload byte signature check, bounded by the payload length.
// ----------------------------------------------------------------------------
module apc_sig_match (
    input  logic [apc_pkg::LEN_W-1:0] i_payload_len,
    input  apc_pkg::t_byte            i_payload_b0,
    input  apc_pkg::t_byte            i_payload_b1,
    input  apc_pkg::t_byte            i_payload_b2,
    input  apc_pkg::t_byte            i_payload_b3,
    input  apc_pkg::t_byte            i_payload_b4,
    output apc_pkg::t_match           o_match
);

    logic len_ge4;
    logic len_ge5;
    logic sig_get;
    logic sig_post;
    logic sig_http;
    logic sig_ssh;
    logic sig_smtp;

    assign len_ge4 = (i_payload_len >= apc_pkg::LEN_W'(4));
    assign len_ge5 = (i_payload_len >= apc_pkg::LEN_W'(5));

    // "GET "
    assign sig_get  = len_ge4 && i_payload_b0 == 8'h47 && i_payload_b1 == 8'h45 &&
                      i_payload_b2 == 8'h54 && i_payload_b3 == 8'h20;
    // "POST "
    assign sig_post = len_ge5 && i_payload_b0 == 8'h50 && i_payload_b1 == 8'h4F &&
                      i_payload_b2 == 8'h53 && i_payload_b3 == 8'h54 &&
                      i_payload_b4 == 8'h20;
    // "HTTP/"
    assign sig_http = len_ge5 && i_payload_b0 == 8'h48 && i_payload_b1 == 8'h54 &&
                      i_payload_b2 == 8'h54 && i_payload_b3 == 8'h50 &&
                      i_payload_b4 == 8'h2F;
    // "SSH-"
    assign sig_ssh  = len_ge4 && i_payload_b0 == 8'h53 && i_payload_b1 == 8'h53 &&
                      i_payload_b2 == 8'h48 && i_payload_b3 == 8'h2D;
    // "SMTP"
    assign sig_smtp = len_ge4 && i_payload_b0 == 8'h53 && i_payload_b1 == 8'h4D &&
                      i_payload_b2 == 8'h54 && i_payload_b3 == 8'h50;

    always_comb begin
        if (sig_get || sig_post || sig_http) begin
            o_match = '{hit: 1'b1, code: apc_pkg::CLASS_HTTP};
        end else if (sig_ssh) begin
            o_match = '{hit: 1'b1, code: apc_pkg::CLASS_SSH};
        end else if (sig_smtp) begin
            o_match = '{hit: 1'b1, code: apc_pkg::CLASS_SMTP};
        end else begin
            o_match = '{hit: 1'b0, code: apc_pkg::CLASS_UNKNOWN};
        end
    end

endmodule

FILE: rtl/app_protocol_port_classifier.sv
// ----------------------------------------------------------------------------
// app_protocol_port_classifier
// Maps one packet header to an application class by port list, then by
// leading payload signature.
// ----------------------------------------------------------------------------
// the input register loads at the input transfer and the result register loads
//   from it when the output advances
// one header per clock while the output is not stalled; the port compare and
//   signature logic sit in a single stage between the two registers
// a stalled output holds its result while the input register can still fill
// reset clears both valid flags; payload registers are not reset
module app_protocol_port_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [apc_pkg::PROTO_W-1:0]   i_ip_protocol,
    input  logic [apc_pkg::PORT_W-1:0]    i_source_port,
    input  logic [apc_pkg::PORT_W-1:0]    i_dest_port,
    input  logic [apc_pkg::LEN_W-1:0]     i_payload_len,
    input  logic [apc_pkg::BYTE_W-1:0]    i_payload_b0,
    input  logic [apc_pkg::BYTE_W-1:0]    i_payload_b1,
    input  logic [apc_pkg::BYTE_W-1:0]    i_payload_b2,
    input  logic [apc_pkg::BYTE_W-1:0]    i_payload_b3,
    input  logic [apc_pkg::BYTE_W-1:0]    i_payload_b4,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [apc_pkg::CLASS_W-1:0]   o_app_class,
    output logic                          o_by_payload
);

    logic                        r_in_valid;
    logic [apc_pkg::PROTO_W-1:0] r_ip_protocol;
    apc_pkg::t_port              r_source_port;
    apc_pkg::t_port              r_dest_port;
    logic [apc_pkg::LEN_W-1:0]   r_payload_len;
    apc_pkg::t_byte              r_payload_b0;
    apc_pkg::t_byte              r_payload_b1;
    apc_pkg::t_byte              r_payload_b2;
    apc_pkg::t_byte              r_payload_b3;
    apc_pkg::t_byte              r_payload_b4;

    logic                        r_out_valid;
    apc_pkg::t_class             r_app_class;
    logic                        r_by_payload;

    apc_pkg::t_match             port_res;
    apc_pkg::t_match             sig_res;
    apc_pkg::t_class             n_app_class;
    logic                        n_by_payload;
    logic                        advance;
    logic                        in_xfer;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ip_protocol <= i_ip_protocol;
            r_source_port <= i_source_port;
            r_dest_port   <= i_dest_port;
            r_payload_len <= i_payload_len;
            r_payload_b0  <= i_payload_b0;
            r_payload_b1  <= i_payload_b1;
            r_payload_b2  <= i_payload_b2;
            r_payload_b3  <= i_payload_b3;
            r_payload_b4  <= i_payload_b4;
        end
    end

    apc_port_match u_port_match (
        .i_ip_protocol (r_ip_protocol),
        .i_source_port (r_source_port),
        .i_dest_port   (r_dest_port),
        .o_match       (port_res)
    );

    apc_sig_match u_sig_match (
        .i_payload_len (r_payload_len),
        .i_payload_b0  (r_payload_b0),
        .i_payload_b1  (r_payload_b1),
        .i_payload_b2  (r_payload_b2),
        .i_payload_b3  (r_payload_b3),
        .i_payload_b4  (r_payload_b4),
        .o_match       (sig_res)
    );

    // port match takes precedence over any payload signature
    always_comb begin
        if (port_res.hit) begin
            n_app_class  = port_res.code;
            n_by_payload = 1'b0;
        end else begin
            n_app_class  = sig_res.code;
            n_by_payload = sig_res.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_app_class  <= n_app_class;
            r_by_payload <= n_by_payload;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_app_class  = r_app_class;
    assign o_by_payload = r_by_payload;

endmodule

FILE: rtl/apc_checker.sv
// ----------------------------------------------------------------------------
// apc_port_checks
// Port-level checks for the application port classifier.
// ----------------------------------------------------------------------------
module apc_port_checks (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [apc_pkg::CLASS_W-1:0] o_app_class,
    input logic                        o_by_payload
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a signature result only ever yields http, ssh or smtp
    a_sig_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_by_payload) |->
            (o_app_class == apc_pkg::CLASS_HTTP || o_app_class == apc_pkg::CLASS_SSH ||
             o_app_class == apc_pkg::CLASS_SMTP))
        else $error("signature result with non-signature class");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_app_class <= apc_pkg::CLASS_MAX))
        else $error("class code out of range");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_app_class) && $stable(o_by_payload)))
        else $error("stalled result changed");

endmodule

bind app_protocol_port_classifier apc_port_checks u_apc_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_app_class  (o_app_class),
    .o_by_payload (o_by_payload)
);

FILE: test/apc_checker.sv
// ----------------------------------------------------------------------------
// apc_checker
// Watches both channels of the port classifier, predicts the class of every
// accepted header and compares each result transfer with the oldest one due.
// ----------------------------------------------------------------------------
module apc_checker
    import apc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [PROTO_W-1:0]   i_ip_protocol,
    input  logic [PORT_W-1:0]    i_source_port,
    input  logic [PORT_W-1:0]    i_dest_port,
    input  logic [LEN_W-1:0]     i_payload_len,
    input  logic [BYTE_W-1:0]    i_payload_b0,
    input  logic [BYTE_W-1:0]    i_payload_b1,
    input  logic [BYTE_W-1:0]    i_payload_b2,
    input  logic [BYTE_W-1:0]    i_payload_b3,
    input  logic [BYTE_W-1:0]    i_payload_b4,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [CLASS_W-1:0]   i_app_class,
    input  logic                 i_by_payload,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_class app_class;
        logic   by_payload;
    } t_verdict;

    // tcp service ports, class code is list position plus one
    localparam t_port TCP_SVC [32] = '{
        16'd80,    16'd443,   16'd21,    16'd22,    16'd23,    16'd25,
        16'd110,   16'd143,   16'd993,   16'd995,   16'd3306,  16'd5432,
        16'd3389,  16'd1723,  16'd5900,  16'd5222,  16'd5223,  16'd5060,
        16'd8080,  16'd8443,  16'd6697,  16'd6667,  16'd27017, 16'd1433,
        16'd3128,  16'd5601,  16'd9200,  16'd9300,  16'd6379,  16'd11211,
        16'd5672,  16'd15672
    };

    localparam t_port UDP_SVC [16] = '{
        16'd53,   16'd67,   16'd68,   16'd69,   16'd123,  16'd161,  16'd162,
        16'd500,  16'd514,  16'd1194, 16'd1701, 16'd1812, 16'd1813, 16'd4500,
        16'd5353, 16'd5060
    };

    localparam t_class UDP_SVC_CODE [16] = '{
        6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
        6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd18
    };

    // signatures left-aligned, first byte in the top bits
    localparam logic [39:0] SIG_GET  = {"GET ", 8'h00};
    localparam logic [39:0] SIG_POST = "POST ";
    localparam logic [39:0] SIG_HTTP = "HTTP/";
    localparam logic [39:0] SIG_SSH  = {"SSH-", 8'h00};
    localparam logic [39:0] SIG_SMTP = {"SMTP", 8'h00};

    t_verdict classes_due [$];
    int       errs = 0;

    function automatic logic sig_hit(input logic [39:0] pl, input logic [LEN_W-1:0] len,
                                     input logic [39:0] sig, input int slen);
        if (len < slen)
            return 1'b0;
        for (int k = 0; k < slen; k++) begin
            if (pl[39-8*k -: 8] != sig[39-8*k -: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_verdict classify_header(input logic [PROTO_W-1:0] proto,
                                                 input t_port sp, input t_port dp,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [39:0] pl);
        t_verdict v;
        v = '0;
        // codes are never zero, so the first listed hit sticks
        if (proto == PROTO_TCP) begin
            for (int i = 0; i < 32; i++) begin
                if (v.app_class == CLASS_UNKNOWN && (TCP_SVC[i] == sp || TCP_SVC[i] == dp))
                    v.app_class = t_class'(i + 1);
            end
        end else if (proto == PROTO_UDP) begin
            for (int i = 0; i < 16; i++) begin
                if (v.app_class == CLASS_UNKNOWN && (UDP_SVC[i] == sp || UDP_SVC[i] == dp))
                    v.app_class = UDP_SVC_CODE[i];
            end
        end
        if (v.app_class == CLASS_UNKNOWN && len != 0) begin
            if (sig_hit(pl, len, SIG_GET, 4) || sig_hit(pl, len, SIG_POST, 5) ||
                sig_hit(pl, len, SIG_HTTP, 5)) begin
                v = '{CLASS_HTTP, 1'b1};
            end else if (sig_hit(pl, len, SIG_SSH, 4)) begin
                v = '{CLASS_SSH, 1'b1};
            end else if (sig_hit(pl, len, SIG_SMTP, 4)) begin
                v = '{CLASS_SMTP, 1'b1};
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (classes_due.size() == 0) begin
                    $error("result transfer with no header waiting: app_class %0d by_payload %0d",
                           i_app_class, i_by_payload);
                    errs++;
                end else begin
                    want = classes_due.pop_front();
                    if (want.app_class !== i_app_class) begin
                        $error("app_class mismatch: expected %0d, actual %0d",
                               want.app_class, i_app_class);
                        errs++;
                    end
                    if (want.by_payload !== i_by_payload) begin
                        $error("by_payload mismatch: expected %0d, actual %0d",
                               want.by_payload, i_by_payload);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                classes_due.push_back(classify_header(i_ip_protocol, i_source_port,
                    i_dest_port, i_payload_len,
                    {i_payload_b0, i_payload_b1, i_payload_b2, i_payload_b3, i_payload_b4}));
        end
        o_fail_count <= errs;
        o_pending    <= classes_due.size();
    end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives packet headers into the port classifier: a directed set covering the
// port lists, list order and payload signature edges, then random headers
// with idle bursts on both channels, a long sink stall and a drain pause.
// ----------------------------------------------------------------------------
module tb;
    import apc_pkg::*;

    localparam int LIMIT        = 100000;
    localparam int RAND_HEADERS = 500;
    localparam int HOLD_CYCLES  = 40;

    localparam logic [39:0] SIGNATURES [5] = '{
        {"GET ", 8'h00}, "POST ", "HTTP/", {"SSH-", 8'h00}, {"SMTP", 8'h00}
    };
    localparam int SIG_LEN [5] = '{4, 5, 5, 4, 4};

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [PROTO_W-1:0]   i_ip_protocol = '0;
    logic [PORT_W-1:0]    i_source_port = '0;
    logic [PORT_W-1:0]    i_dest_port   = '0;
    logic [LEN_W-1:0]     i_payload_len = '0;
    logic [BYTE_W-1:0]    i_payload_b0  = '0;
    logic [BYTE_W-1:0]    i_payload_b1  = '0;
    logic [BYTE_W-1:0]    i_payload_b2  = '0;
    logic [BYTE_W-1:0]    i_payload_b3  = '0;
    logic [BYTE_W-1:0]    i_payload_b4  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [CLASS_W-1:0]   o_app_class;
    logic                 o_by_payload;

    int   fail_count;
    int   pending;
    int   hold_ask   = 0;
    int   holds_done = 0;
    logic calm       = 1'b0;
    int   cycle_cnt  = 0;

    always #5 i_clk = ~i_clk;

    app_protocol_port_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_ip_protocol (i_ip_protocol),
        .i_source_port (i_source_port),
        .i_dest_port   (i_dest_port),
        .i_payload_len (i_payload_len),
        .i_payload_b0  (i_payload_b0),
        .i_payload_b1  (i_payload_b1),
        .i_payload_b2  (i_payload_b2),
        .i_payload_b3  (i_payload_b3),
        .i_payload_b4  (i_payload_b4),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_app_class   (o_app_class),
        .o_by_payload  (o_by_payload)
    );

    apc_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_ip_protocol (i_ip_protocol),
        .i_source_port (i_source_port),
        .i_dest_port   (i_dest_port),
        .i_payload_len (i_payload_len),
        .i_payload_b0  (i_payload_b0),
        .i_payload_b1  (i_payload_b1),
        .i_payload_b2  (i_payload_b2),
        .i_payload_b3  (i_payload_b3),
        .i_payload_b4  (i_payload_b4),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_app_class   (o_app_class),
        .i_by_payload  (o_by_payload),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic t_port pick_port();
        case ($urandom_range(0, 9))
            0, 1, 2: return TCP_PORTS[$urandom_range(0, NUM_TCP - 1)];
            3, 4:    return UDP_PORTS[$urandom_range(0, NUM_UDP - 1)];
            5:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return t_port'($urandom);
        endcase
    endfunction

    // offer one header, hold it until the transfer, then maybe idle a little
    task automatic send_header(input logic [PROTO_W-1:0] proto, input t_port sp,
                               input t_port dp, input logic [LEN_W-1:0] len,
                               input logic [39:0] pl);
        i_in_valid    <= 1'b1;
        i_ip_protocol <= proto;
        i_source_port <= sp;
        i_dest_port   <= dp;
        i_payload_len <= len;
        {i_payload_b0, i_payload_b1, i_payload_b2, i_payload_b3, i_payload_b4} <= pl;
        do @(posedge i_clk); while (!o_in_ready);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // sink side: random ready bursts plus one long stall on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_ask != holds_done) begin
                holds_done = holds_done + 1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int                 k;
        logic [PROTO_W-1:0] proto;
        t_port              sp;
        t_port              dp;
        logic [LEN_W-1:0]   len;
        logic [39:0]        pl;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // port hits, list order and protocol selection
        send_header(PROTO_TCP, 16'd80, 16'd1000, 16'd0, 40'h0);
        send_header(PROTO_TCP, 16'd40000, 16'd15672, 16'd10, SIGNATURES[0]);
        send_header(PROTO_TCP, 16'd15672, 16'd80, 16'd0, 40'h0);
        send_header(PROTO_TCP, 16'd5223, 16'd5222, 16'd0, 40'h0);
        send_header(PROTO_TCP, 16'd8443, 16'd8080, 16'd0, 40'h0);
        send_header(PROTO_TCP, 16'd11211, 16'd9, 16'd0, 40'h0);
        send_header(PROTO_TCP, 16'd443, 16'd443, 16'd5, SIGNATURES[3]);
        send_header(PROTO_UDP, 16'd53, 16'd5353, 16'd0, 40'h0);
        send_header(PROTO_UDP, 16'd5060, 16'd0, 16'd0, 40'h0);
        send_header(PROTO_UDP, 16'd4500, 16'd1813, 16'd0, 40'h0);
        send_header(PROTO_UDP, 16'd68, 16'd67, 16'd0, 40'h0);
        // ports of the other list fall through to the payload
        send_header(PROTO_UDP, 16'd80, 16'd443, 16'd5, SIGNATURES[2]);
        send_header(PROTO_TCP, 16'd53, 16'd67, 16'd4, SIGNATURES[3] | 40'h5A);
        // non tcp/udp protocols only look at the payload
        send_header(8'd0, 16'd80, 16'd22, 16'd4, SIGNATURES[4]);
        send_header(8'hFF, 16'd0, 16'd0, 16'd5, SIGNATURES[1]);
        send_header(8'd7, 16'd53, 16'd53, 16'd4, SIGNATURES[0]);
        // payload shorter than the signature
        send_header(PROTO_TCP, 16'd0, 16'hFFFF, 16'd4, SIGNATURES[1]);
        send_header(PROTO_TCP, 16'd1, 16'd2, 16'd3, SIGNATURES[4]);
        send_header(8'd1, 16'd3, 16'd4, 16'd4, SIGNATURES[2]);
        send_header(PROTO_TCP, 16'hFFFF, 16'd0, 16'd2, SIGNATURES[0]);
        // empty payload never matches; then maximum lengths and a near miss
        send_header(PROTO_UDP, 16'd1, 16'd2, 16'd0, SIGNATURES[0]);
        send_header(PROTO_UDP, 16'd1, 16'd2, 16'hFFFF, SIGNATURES[0]);
        send_header(8'd16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 40'hFF_FFFF_FFFF);
        send_header(PROTO_TCP, 16'd7, 16'd8, 16'd5, {"GETX", 8'h20});

        for (int n = 0; n < RAND_HEADERS; n++) begin
            // sink stalls while headers keep coming, filling the pipe
            if (n == 120)
                hold_ask <= hold_ask + 1;
            if (n == 260)
                drain();
            if (n == RAND_HEADERS - 100)
                calm <= 1'b1;

            case ($urandom_range(0, 9))
                0, 1, 2, 3: proto = PROTO_TCP;
                4, 5, 6:    proto = PROTO_UDP;
                7:          proto = 8'($urandom_range(0, 255));
                8:          proto = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:    proto = PROTO_TCP ^ (8'h1 << $urandom_range(0, 7));
            endcase
            sp = pick_port();
            dp = pick_port();
            if ($urandom_range(0, 9) < 6) begin
                k  = $urandom_range(0, 4);
                pl = SIGNATURES[k];
                if (SIG_LEN[k] == 4)
                    pl[7:0] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 4) == 0) begin
                    k = $urandom_range(0, 39);
                    pl[k] = ~pl[k];
                    k = $urandom_range(0, 4);
                end
                case ($urandom_range(0, 3))
                    0:       len = 16'(SIG_LEN[k]);
                    1:       len = 16'(SIG_LEN[k] - 1);
                    2:       len = 16'($urandom_range(0, 8));
                    default: len = 16'($urandom);
                endcase
            end else begin
                pl  = {$urandom, 8'($urandom)};
                len = $urandom_range(0, 1) ? 16'($urandom_range(0, 6)) : 16'($urandom);
            end
            send_header(proto, sp, dp, len, pl);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
